// File: design/ssc_pkg.sv
// Shared types and constants for the sun sensor calibration unit.
package ssc_pkg;

    localparam int unsigned COEF_SLOTS = 6;
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned MAXV_W     = 15;
    localparam int unsigned TERM_W     = 3;
    localparam int unsigned COEF_W     = 18;
    localparam int unsigned X_W        = 16;
    localparam int unsigned T_W        = 18;
    localparam int unsigned ACC_W      = 40;
    localparam int unsigned OUT_W      = 21;
    localparam int unsigned ADDR_W     = 5;
    localparam int unsigned DATA_W     = 32;

    localparam logic signed [T_W-1:0]   T_ONE    = 18'sd65536;
    localparam logic signed [T_W-1:0]   T_NEG    = -18'sd65536;
    localparam logic signed [OUT_W-1:0] OUT_MAXV = 21'sd1048575;
    localparam logic signed [OUT_W-1:0] OUT_MINV = -21'sd1048576;

    // register index (paddr[4:2])
    typedef enum logic [2:0] {
        REG_MAX_VALUE  = 3'd0,
        REG_TERM_COUNT = 3'd1,
        REG_COEF_0     = 3'd2,
        REG_COEF_1     = 3'd3,
        REG_COEF_2     = 3'd4,
        REG_COEF_3     = 3'd5,
        REG_COEF_4     = 3'd6,
        REG_COEF_5     = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [MAXV_W-1:0]                   max_value;
        logic [TERM_W-1:0]                   term_count;
        logic [COEF_SLOTS-1:0][COEF_W-1:0]   coef;
    } t_cfg;

    // classified item held in the queue
    typedef struct packed {
        logic [MAXV_W-1:0] sample;
        logic              ok;
        logic              fe;
    } t_qent;

endpackage

// File: design/ssc_if.sv
// Valid/ready channel interfaces for samples and results.
interface ssc_in_if;
    logic                     valid;
    logic                     ready;
    logic signed [15:0]       raw_sample;
    logic                     frame_end;

    modport source (output valid, output raw_sample, output frame_end, input ready);
    modport sink   (input valid, input raw_sample, input frame_end, output ready);
endinterface

interface ssc_out_if;
    logic                     valid;
    logic                     ready;
    logic signed [20:0]       cos_value;
    logic                     in_range;
    logic                     frame_end_out;

    modport source (output valid, output cos_value, output in_range, output frame_end_out,
                    input ready);
    modport sink   (input valid, input cos_value, input in_range, input frame_end_out,
                    output ready);
endinterface

// File: design/ssc_cfg.sv
// APB register file: full scale, term count and series coefficients.
module ssc_cfg
    import ssc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_value  <= 15'd32767;
            r_cfg.term_count <= '0;
            r_cfg.coef       <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_MAX_VALUE:  r_cfg.max_value  <= pwdata[MAXV_W-1:0];
                REG_TERM_COUNT: r_cfg.term_count <= pwdata[TERM_W-1:0];
                REG_COEF_0:     r_cfg.coef[0]    <= pwdata[COEF_W-1:0];
                REG_COEF_1:     r_cfg.coef[1]    <= pwdata[COEF_W-1:0];
                REG_COEF_2:     r_cfg.coef[2]    <= pwdata[COEF_W-1:0];
                REG_COEF_3:     r_cfg.coef[3]    <= pwdata[COEF_W-1:0];
                REG_COEF_4:     r_cfg.coef[4]    <= pwdata[COEF_W-1:0];
                REG_COEF_5:     r_cfg.coef[5]    <= pwdata[COEF_W-1:0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_MAX_VALUE:  prdata = DATA_W'(r_cfg.max_value);
            REG_TERM_COUNT: prdata = DATA_W'(r_cfg.term_count);
            REG_COEF_0:     prdata = DATA_W'(r_cfg.coef[0]);
            REG_COEF_1:     prdata = DATA_W'(r_cfg.coef[1]);
            REG_COEF_2:     prdata = DATA_W'(r_cfg.coef[2]);
            REG_COEF_3:     prdata = DATA_W'(r_cfg.coef[3]);
            REG_COEF_4:     prdata = DATA_W'(r_cfg.coef[4]);
            REG_COEF_5:     prdata = DATA_W'(r_cfg.coef[5]);
            default:        prdata = '0;
        endcase
    end

endmodule

// File: design/ssc_front.sv
// Front end: range check of each sample and a two-entry queue to the back end.
module ssc_front
    import ssc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    ssc_in_if.sink            i_in,
    input  logic [MAXV_W-1:0] i_max_value,
    input  logic              i_pop,
    output logic              o_head_valid,
    output t_qent             o_head
);

    t_qent      r_ent [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;
    t_qent      w_new;

    // in range when non-negative and below full scale (zero full scale: never)
    always_comb begin
        w_new.sample = i_in.raw_sample[MAXV_W-1:0];
        w_new.fe     = i_in.frame_end;
        w_new.ok     = !i_in.raw_sample[SAMPLE_W-1] &&
                       (i_in.raw_sample[MAXV_W-1:0] < i_max_value);
    end

    assign i_in.ready   = (r_cnt != 2'd2);
    assign w_push       = i_in.valid && i_in.ready;
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_ent[r_rp];
    assign w_pop        = o_head_valid && i_pop;

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_ent[r_wp] <= w_new;
    end

endmodule

// File: design/ssc_back.sv
// Back end: restoring divider, Chebyshev recurrence rounds and output register.
module ssc_back
    import ssc_pkg::*;
#(
    parameter int unsigned MAX_TERMS = 6
)(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_valid,
    input  t_qent   i_item,
    output logic    o_ready,
    ssc_out_if.source o_out
);

    localparam int unsigned DIV_N = X_W;

    logic w_en;

    // divider stages: one quotient bit per stage
    logic              r_dv_v   [1:DIV_N];
    logic [MAXV_W-1:0] r_dv_rem [1:DIV_N];
    logic [X_W-1:0]    r_dv_q   [1:DIV_N];
    logic              r_dv_ok  [1:DIV_N];
    logic              r_dv_fe  [1:DIV_N];
    logic [MAXV_W-1:0] n_dv_rem [DIV_N];
    logic [X_W-1:0]    n_dv_q   [DIV_N];

    // recurrence rounds, two stages each (multiply, then add)
    logic                     r_m_v   [MAX_TERMS];
    logic [X_W-1:0]           r_m_x   [MAX_TERMS];
    logic signed [T_W-1:0]    r_m_tc  [MAX_TERMS];
    logic signed [T_W-1:0]    r_m_tn  [MAX_TERMS];
    logic signed [ACC_W-1:0]  r_m_acc [MAX_TERMS];
    logic signed [35:0]       r_m_cp  [MAX_TERMS];
    logic signed [34:0]       r_m_p   [MAX_TERMS];
    logic                     r_m_ok  [MAX_TERMS];
    logic                     r_m_fe  [MAX_TERMS];

    logic                     r_a_v   [MAX_TERMS];
    logic [X_W-1:0]           r_a_x   [MAX_TERMS];
    logic signed [T_W-1:0]    r_a_tc  [MAX_TERMS];
    logic signed [T_W-1:0]    r_a_tn  [MAX_TERMS];
    logic signed [ACC_W-1:0]  r_a_acc [MAX_TERMS];
    logic                     r_a_ok  [MAX_TERMS];
    logic                     r_a_fe  [MAX_TERMS];

    logic                     s_v   [MAX_TERMS];
    logic [X_W-1:0]           s_x   [MAX_TERMS];
    logic signed [T_W-1:0]    s_tc  [MAX_TERMS];
    logic signed [T_W-1:0]    s_tn  [MAX_TERMS];
    logic signed [ACC_W-1:0]  s_acc [MAX_TERMS];
    logic                     s_ok  [MAX_TERMS];
    logic                     s_fe  [MAX_TERMS];
    logic signed [ACC_W-1:0]  n_a_acc [MAX_TERMS];
    logic signed [T_W-1:0]    n_a_tn  [MAX_TERMS];

    logic [TERM_W-1:0] w_n;

    logic                     r_o_v;
    logic signed [OUT_W-1:0]  r_o_val;
    logic                     r_o_ok;
    logic                     r_o_fe;
    logic signed [OUT_W-1:0]  n_o_val;

    // whole pipeline advances unless the result is held
    assign w_en    = !r_o_v || o_out.ready;
    assign o_ready = w_en;

    assign w_n = (i_cfg.term_count > TERM_W'(MAX_TERMS)) ? TERM_W'(MAX_TERMS)
                                                         : i_cfg.term_count;

    // divider step logic
    always_comb begin
        logic [MAXV_W-1:0] rem_in;
        logic [X_W-1:0]    q_in;
        logic [X_W-1:0]    t;
        logic              ge;
        for (int i = 0; i < DIV_N; i++) begin
            rem_in = (i == 0) ? i_item.sample : r_dv_rem[i];
            q_in   = (i == 0) ? '0 : r_dv_q[i];
            t      = {rem_in, 1'b0};
            ge     = (t >= {1'b0, i_cfg.max_value});
            n_dv_rem[i] = ge ? MAXV_W'(t - {1'b0, i_cfg.max_value}) : MAXV_W'(t);
            n_dv_q[i]   = {q_in[X_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 1; i <= DIV_N; i++) r_dv_v[i] <= 1'b0;
        end else if (w_en) begin
            r_dv_v[1] <= i_valid;
            for (int i = 2; i <= DIV_N; i++) r_dv_v[i] <= r_dv_v[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_ok[1] <= i_item.ok;
            r_dv_fe[1] <= i_item.fe;
            for (int i = 2; i <= DIV_N; i++) begin
                r_dv_ok[i] <= r_dv_ok[i-1];
                r_dv_fe[i] <= r_dv_fe[i-1];
            end
            for (int i = 1; i <= DIV_N; i++) begin
                r_dv_rem[i] <= n_dv_rem[i-1];
                r_dv_q[i]   <= n_dv_q[i-1];
            end
        end
    end

    // round inputs: round 0 starts with T0 = 1, T1 = x
    always_comb begin
        for (int j = 0; j < MAX_TERMS; j++) begin
            if (j == 0) begin
                s_v[j]   = r_dv_v[DIV_N];
                s_x[j]   = r_dv_q[DIV_N];
                s_tc[j]  = T_ONE;
                s_tn[j]  = $signed({2'b00, r_dv_q[DIV_N]});
                s_acc[j] = '0;
                s_ok[j]  = r_dv_ok[DIV_N];
                s_fe[j]  = r_dv_fe[DIV_N];
            end else begin
                s_v[j]   = r_a_v[j-1];
                s_x[j]   = r_a_x[j-1];
                s_tc[j]  = r_a_tc[j-1];
                s_tn[j]  = r_a_tn[j-1];
                s_acc[j] = r_a_acc[j-1];
                s_ok[j]  = r_a_ok[j-1];
                s_fe[j]  = r_a_fe[j-1];
            end
        end
    end

    // add: acc += c_j*T_j if j < w_n; next T floor(2x*T/65536) - T_prev, clamped
    always_comb begin
        logic signed [19:0] sh;
        logic signed [20:0] d;
        for (int j = 0; j < MAX_TERMS; j++) begin
            n_a_acc[j] = (TERM_W'(j) < w_n) ? r_m_acc[j] + ACC_W'(r_m_cp[j]) : r_m_acc[j];
            sh = r_m_p[j][34:15];
            d  = 21'(sh) - 21'(r_m_tc[j]);
            if (d < 21'(T_NEG))      n_a_tn[j] = T_NEG;
            else if (d > 21'(T_ONE)) n_a_tn[j] = T_ONE;
            else                     n_a_tn[j] = d[T_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_TERMS; j++) begin
                r_m_v[j] <= 1'b0;
                r_a_v[j] <= 1'b0;
            end
        end else if (w_en) begin
            for (int j = 0; j < MAX_TERMS; j++) begin
                r_m_v[j] <= s_v[j];
                r_a_v[j] <= r_m_v[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < MAX_TERMS; j++) begin
                r_m_x[j]   <= s_x[j];
                r_m_tc[j]  <= s_tc[j];
                r_m_tn[j]  <= s_tn[j];
                r_m_acc[j] <= s_acc[j];
                r_m_ok[j]  <= s_ok[j];
                r_m_fe[j]  <= s_fe[j];
                r_m_cp[j]  <= $signed(i_cfg.coef[j]) * s_tc[j];
                r_m_p[j]   <= $signed({1'b0, s_x[j]}) * s_tn[j];
                r_a_x[j]   <= r_m_x[j];
                r_a_tc[j]  <= r_m_tn[j];
                r_a_tn[j]  <= n_a_tn[j];
                r_a_acc[j] <= n_a_acc[j];
                r_a_ok[j]  <= r_m_ok[j];
                r_a_fe[j]  <= r_m_fe[j];
            end
        end
    end

    // final: add x, drop 16 fraction bits, saturate, zero when out of range
    always_comb begin
        logic signed [ACC_W-1:0] sum;
        logic signed [23:0]      f;
        sum = r_a_acc[MAX_TERMS-1] + $signed({8'd0, r_a_x[MAX_TERMS-1], 16'd0});
        f   = sum[39:16];
        if (!r_a_ok[MAX_TERMS-1])  n_o_val = '0;
        else if (f > 24'(OUT_MAXV)) n_o_val = OUT_MAXV;
        else if (f < 24'(OUT_MINV)) n_o_val = OUT_MINV;
        else                        n_o_val = f[OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (w_en) begin
            r_o_v <= r_a_v[MAX_TERMS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_val <= n_o_val;
            r_o_ok  <= r_a_ok[MAX_TERMS-1];
            r_o_fe  <= r_a_fe[MAX_TERMS-1];
        end
    end

    assign o_out.valid         = r_o_v;
    assign o_out.cos_value     = r_o_val;
    assign o_out.in_range      = r_o_ok;
    assign o_out.frame_end_out = r_o_fe;

endmodule

// File: design/sun_sensor_chebyshev_calibration_unit.sv
// Path: an item taken into the queue passes the divider stages, the recurrence rounds
// and the output register before the result shows valid.
// Throughput: one item per cycle; the back end is a single pipeline that stalls
// as a whole when the output register is held, and the two-entry queue keeps
// the input side taking items meanwhile until both entries are full.
// Reset (synchronous, active low) empties queue and pipeline, loads register defaults.
module sun_sensor_chebyshev_calibration_unit
    import ssc_pkg::*;
#(
    parameter int unsigned MAX_TERMS = 6
)(
    input  logic              i_clk,
    input  logic              i_rst_n,
    ssc_in_if.sink            i_in,
    ssc_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg  w_cfg;
    t_qent w_head;
    logic  w_head_v;
    logic  w_back_rdy;

    ssc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ssc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_max_value  (w_cfg.max_value),
        .i_pop        (w_back_rdy),
        .o_head_valid (w_head_v),
        .o_head       (w_head)
    );

    ssc_back #(.MAX_TERMS(MAX_TERMS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_head_v),
        .i_item  (w_head),
        .o_ready (w_back_rdy),
        .o_out   (o_out)
    );

endmodule

// File: design/ssc_checker.sv
// Port-level assertions for the calibration unit, bound to the top level.
module ssc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [20:0] i_cos_value,
    input logic        i_in_range,
    input logic        i_fe_out
);

    // a held result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // out-of-range item reads zero
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_in_range |-> i_cos_value == 21'd0)
        else $error("out-of-range item with nonzero value");

    // nothing offered right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered after reset");

    // stalled fields hold
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_cos_value) && $stable(i_in_range) && $stable(i_fe_out))
        else $error("result changed while stalled");

endmodule

bind sun_sensor_chebyshev_calibration_unit ssc_checker u_ssc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_cos_value (o_out.cos_value),
    .i_in_range  (o_out.in_range),
    .i_fe_out    (o_out.frame_end_out)
);
